FILE: hw/rtl/mfrf_pkg.sv
// Shared types and constants for the monochrome framebuffer rectangle fill core.
// Depends on nothing; imported by mono_framebuffer_rect_fill_core and its testbench.
package mfrf_pkg;

  localparam int FbWords   = 512;
  localparam int AddrW     = 9;
  localparam int WordW     = 16;
  localparam int LastCol   = 127;
  localparam int LastRow   = 63;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_FILL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  // Bits of one word covered by in-word columns lo..hi (lo <= hi).
  function automatic logic [WordW-1:0] span_mask(input logic [3:0] lo, input logic [3:0] hi);
    logic [WordW-1:0] left;
    logic [WordW-1:0] right;
    left  = {WordW{1'b1}} >> lo;
    right = {WordW{1'b1}} << (4'd15 - hi);
    return left & right;
  endfunction

endpackage

FILE: hw/rtl/mono_framebuffer_rect_fill_core.sv
// Monochrome 128x64 framebuffer core: 512x16 word store with pixel, rectangle,
// clear-all and word-read commands. Depends on mfrf_pkg.
//
// Usage:
//   A command beat is taken when start is high and busy is low. Every command
//   produces exactly one result beat: done pulses for one cycle with done_res
//   set, and read_data carries the addressed word for a read (zero otherwise).
//   The receiver cannot stall; the result is gone after its one cycle.
// Command steps (all paths share one single-port-write, registered-read
//   word memory, so each word touched takes a read state and a write state):
//   - put pixel: one word read and written, done in the cycle after the write.
//   - fill rectangle: a read and a write per word touched, rows x edge-to-edge
//     words, at most 64 x 8 words; an empty rectangle completes at once.
//   - clear all: zeroes all 512 words, one word per cycle.
//   - read word: rdata is loaded as the beat is taken, then passed out from S_RWAIT.
//   A new command can be taken in the cycle in which done is shown.
// Reset:
//   rst (synchronous) starts a clearing pass that zeroes all 512 store words;
//   busy stays high during that pass and no result is produced for it.
module mono_framebuffer_rect_fill_core
  import mfrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode,
  input  logic [6:0]       pos_x,
  input  logic [5:0]       pos_y,
  input  logic [7:0]       rect_width,
  input  logic [6:0]       rect_height,
  input  logic             color,
  input  logic [8:0]       word_index,
  output logic             done,
  output logic [WordW-1:0] read_data,
  output logic             done_res
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_WR,
    S_RWAIT
  } state_t;

  state_t           state;
  logic [5:0]       row;
  logic [5:0]       row_end;
  logic [2:0]       col;
  logic [2:0]       col_first;
  logic [2:0]       col_last;
  logic [3:0]       bit_lo;
  logic [3:0]       bit_hi;
  logic             fill_color;
  logic [AddrW-1:0] clr_addr;
  logic             clr_cmd;

  logic [WordW-1:0] mem [FbWords];
  logic [WordW-1:0] rdata;

  logic             accept;
  logic [8:0]       x_end_raw;
  logic [7:0]       y_end_raw;
  logic [6:0]       x_end;
  logic [5:0]       y_end;
  logic             rect_empty;
  logic [3:0]       mask_lo;
  logic [3:0]       mask_hi;
  logic [WordW-1:0] mask;
  logic [AddrW-1:0] cur_addr;
  logic [AddrW-1:0] mem_raddr;
  logic [AddrW-1:0] mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic             mem_we;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Clip rectangle corners to the display edges
  assign x_end_raw  = {2'b00, pos_x} + {1'b0, rect_width} - 9'd1;
  assign y_end_raw  = {2'b00, pos_y} + {1'b0, rect_height} - 8'd1;
  assign x_end      = (x_end_raw > 9'(LastCol)) ? 7'(LastCol) : x_end_raw[6:0];
  assign y_end      = (y_end_raw > 8'(LastRow)) ? 6'(LastRow) : y_end_raw[5:0];
  assign rect_empty = (rect_width == 8'd0) || (rect_height == 7'd0);

  // Edge-word mask of the current word column
  assign mask_lo = (col == col_first) ? bit_lo : 4'd0;
  assign mask_hi = (col == col_last) ? bit_hi : 4'd15;
  assign mask    = span_mask(mask_lo, mask_hi);

  // Rows 32-63 land in the right half of rows 0-31
  assign cur_addr = {row[4:0], row[5], col};

  // Select memory port addresses and write data
  always_comb begin
    mem_raddr = cur_addr;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = fill_color ? (rdata | mask) : (rdata & ~mask);
    case (state)
      S_IDLE: begin
        mem_raddr = word_index;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Word store: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Command sequencer and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_cmd   <= 1'b0;
      done      <= 1'b0;
      done_res  <= 1'b0;
      read_data <= '0;
    end else begin
      done      <= 1'b0;
      done_res  <= 1'b0;
      read_data <= '0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 9'd1;
          if (clr_addr == 9'(FbWords - 1)) begin
            state    <= S_IDLE;
            done     <= clr_cmd;
            done_res <= clr_cmd;
            clr_cmd  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            fill_color <= color;
            case (opcode_t'(opcode))
              OP_PIXEL: begin
                row       <= pos_y;
                row_end   <= pos_y;
                col       <= pos_x[6:4];
                col_first <= pos_x[6:4];
                col_last  <= pos_x[6:4];
                bit_lo    <= pos_x[3:0];
                bit_hi    <= pos_x[3:0];
                state     <= S_RD;
              end
              OP_FILL: begin
                row       <= pos_y;
                row_end   <= y_end;
                col       <= pos_x[6:4];
                col_first <= pos_x[6:4];
                col_last  <= x_end[6:4];
                bit_lo    <= pos_x[3:0];
                bit_hi    <= x_end[3:0];
                if (rect_empty) begin
                  done     <= 1'b1;
                  done_res <= 1'b1;
                end else begin
                  state <= S_RD;
                end
              end
              OP_CLEAR: begin
                clr_addr <= '0;
                clr_cmd  <= 1'b1;
                state    <= S_CLEAR;
              end
              OP_READ: begin
                state <= S_RWAIT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          // Advance across the row, then down to the next row
          if (col == col_last) begin
            if (row == row_end) begin
              state    <= S_IDLE;
              done     <= 1'b1;
              done_res <= 1'b1;
            end else begin
              row   <= row + 6'd1;
              col   <= col_first;
              state <= S_RD;
            end
          end else begin
            col   <= col + 3'd1;
            state <= S_RD;
          end
        end
        S_RWAIT: begin
          read_data <= rdata;
          done      <= 1'b1;
          done_res  <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result beat never overlaps work on the store
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while a command is still running");

  // Nothing is written to the store while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  // Every word visited by a fill has at least one covered bit
  a_mask_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (mask != '0))
    else $error("read-modify-write with an empty mask");

  // Word column walk stays between the edge words
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> ((col >= col_first) && (col <= col_last)))
    else $error("word column outside the rectangle");

  // Read data only travels with a result beat
  a_data_with_done: assert property (@(posedge clk) disable iff (rst)
    (read_data != '0) |-> done)
    else $error("read data without a result beat");

endmodule

FILE: test/mono_framebuffer_rect_fill_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the 128x64 monochrome framebuffer core: directed rows, then random
// pixel, rectangle, clear and read beats checked against a shadow copy of the frame store.
// Depends on mfrf_pkg and mono_framebuffer_rect_fill_core.
module mono_framebuffer_rect_fill_core_tb;
  import mfrf_pkg::*;

  typedef struct {
    opcode_t     op;
    logic [6:0]  x;
    logic [5:0]  y;
    logic [7:0]  w;
    logic [6:0]  h;
    logic        c;
    logic [8:0]  wi;
    logic        typed;
    logic [15:0] typed_word;
  } fb_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = OP_PIXEL;
  logic [6:0]  pos_x = '0;
  logic [5:0]  pos_y = '0;
  logic [7:0]  rect_width = '0;
  logic [6:0]  rect_height = '0;
  logic        color = 1'b0;
  logic [8:0]  word_index = '0;
  logic        done;
  logic [15:0] read_data;
  logic        done_res;

  // Hand-typed read value that rides along with a directed beat.
  logic        row_typed = 1'b0;
  logic [15:0] row_word = '0;

  logic [15:0] shadow_frame [FbWords];
  logic [15:0] pending_words [$];
  int          fault_count = 0;

  always #4 clk = ~clk;

  mono_framebuffer_rect_fill_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .color       (color),
    .word_index  (word_index),
    .done        (done),
    .read_data   (read_data),
    .done_res    (done_res)
  );

  task automatic flag_error(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fault_count++;
  endtask

  // Word address of the word holding display column col on display row row.
  function automatic int word_at(input int row, input int col);
    if (row < 32) return row * 16 + col / 16;
    return (row - 32) * 16 + 8 + col / 16;
  endfunction

  task automatic paint_pixel(input int row, input int col, input logic c);
    int a;
    a = word_at(row, col);
    shadow_frame[9'(a)][4'(15 - (col % 16))] = c;
  endtask

  // Apply one command to the shadow frame and return the word it reads back.
  task automatic run_command(input opcode_t op, input int x, input int y, input int w,
                             input int h, input logic c, input int wi,
                             output logic [15:0] word);
    int xe;
    int ye;
    word = '0;
    case (op)
      OP_PIXEL: paint_pixel(y, x, c);
      OP_FILL: begin
        if (w != 0 && h != 0) begin
          xe = (x + w - 1 > LastCol) ? LastCol : x + w - 1;
          ye = (y + h - 1 > LastRow) ? LastRow : y + h - 1;
          for (int r = y; r <= ye; r++)
            for (int col = x; col <= xe; col++)
              paint_pixel(r, col, c);
        end
      end
      OP_CLEAR: foreach (shadow_frame[i]) shadow_frame[i] = '0;
      default: word = shadow_frame[9'(wi)];
    endcase
  endtask

  initial foreach (shadow_frame[i]) shadow_frame[i] = '0;

  // Check result beats against the oldest expectation, then log newly taken commands.
  always @(posedge clk) begin : scoreboard
    logic [15:0] want;
    if (!rst && done !== 1'b0) begin
      if (pending_words.size() == 0) begin
        flag_error("result beat with nothing outstanding");
      end else begin
        want = pending_words.pop_front();
        if (read_data !== want)
          flag_error($sformatf("read_data %h, expected %h", read_data, want));
        if (done_res !== 1'b1)
          flag_error($sformatf("done_res %b, expected 1", done_res));
      end
    end
    if (!rst && start && !busy) begin
      run_command(opcode_t'(opcode), int'(pos_x), int'(pos_y), int'(rect_width),
                  int'(rect_height), color, int'(word_index), want);
      if (row_typed) want = row_word;
      pending_words.push_back(want);
    end
  end

  // Drive one command beat after an optional gap; return at the edge that takes it.
  task automatic send_beat(input fb_cmd_t cmd, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode      <= cmd.op;
    pos_x       <= cmd.x;
    pos_y       <= cmd.y;
    rect_width  <= cmd.w;
    rect_height <= cmd.h;
    color       <= cmd.c;
    word_index  <= cmd.wi;
    row_typed   <= cmd.typed;
    row_word    <= cmd.typed_word;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending_words.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic fb_cmd_t make_cmd(input opcode_t op, input int x, input int y,
                                       input int w, input int h, input int c,
                                       input int wi, input logic typed = 1'b0,
                                       input logic [15:0] typed_word = '0);
    fb_cmd_t cmd;
    cmd.op = op;
    cmd.x = 7'(x);
    cmd.y = 6'(y);
    cmd.w = 8'(w);
    cmd.h = 7'(h);
    cmd.c = 1'(c);
    cmd.wi = 9'(wi);
    cmd.typed = typed;
    cmd.typed_word = typed_word;
    return cmd;
  endfunction

  // Mostly small rectangles; a few span the full field ranges.
  function automatic fb_cmd_t random_cmd();
    fb_cmd_t cmd;
    int pick;
    pick = $urandom_range(99);
    cmd = make_cmd(OP_READ, $urandom_range(127), $urandom_range(63), $urandom_range(255),
                   $urandom_range(127), $urandom_range(1), $urandom_range(511));
    if (pick < 35) begin
      cmd.op = OP_PIXEL;
    end else if (pick < 67) begin
      cmd.op = OP_FILL;
      if ($urandom_range(99) < 85) begin
        cmd.w = 8'($urandom_range(24));
        cmd.h = 7'($urandom_range(6));
      end
    end else if (pick < 70) begin
      cmd.op = OP_CLEAR;
    end
    return cmd;
  endfunction

  function automatic int pick_gap(input int idle_pct);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    return gap;
  endfunction

  initial begin : stimulus
    fb_cmd_t rows [$];
    int idle_pct [3];
    int gap;
    idle_pct = '{0, 63, 29};

    // Directed rows: reset state, corners, full fill, edge clipping, empty rectangles, clear.
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1'b1, 16'h0000));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 511, 1'b1, 16'h0000));
    rows.push_back(make_cmd(OP_PIXEL, 0, 0, 0, 0, 1, 0));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1'b1, 16'h8000));
    rows.push_back(make_cmd(OP_PIXEL, 127, 63, 0, 0, 1, 0));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 511, 1'b1, 16'h0001));
    rows.push_back(make_cmd(OP_FILL, 0, 0, 128, 64, 1, 0));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1'b1, 16'hffff));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 511, 1'b1, 16'hffff));
    rows.push_back(make_cmd(OP_FILL, 3, 0, 4, 1, 0, 0));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    rows.push_back(make_cmd(OP_FILL, 120, 10, 255, 2, 0, 0));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 167));
    rows.push_back(make_cmd(OP_FILL, 16, 60, 20, 127, 0, 0));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 505));
    rows.push_back(make_cmd(OP_FILL, 5, 5, 0, 5, 0, 0));
    rows.push_back(make_cmd(OP_FILL, 5, 5, 5, 0, 0, 0));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 80));
    rows.push_back(make_cmd(OP_PIXEL, 64, 40, 0, 0, 0, 0));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 140));
    rows.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 1, 0));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1'b1, 16'h0000));
    rows.push_back(make_cmd(OP_READ, 0, 0, 0, 0, 0, 300, 1'b1, 16'h0000));
    rows.push_back(make_cmd(OP_PIXEL, 127, 63, 255, 127, 1, 511));
    rows.push_back(make_cmd(OP_FILL, 127, 63, 255, 127, 1, 511));
    rows.push_back(make_cmd(OP_READ, 127, 63, 255, 127, 1, 511));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_beat(rows[i], 0);
    drain_results();

    // Random phases with different sender idle rates; every 50 beats open with a burst.
    foreach (idle_pct[p]) begin
      for (int n = 0; n < 484; n++) begin
        gap = (n % 50 < 10) ? 0 : pick_gap(idle_pct[p]);
        send_beat(random_cmd(), gap);
      end
      drain_results();
    end

    repeat (16) @(posedge clk);
    if (fault_count == 0) begin
      $display("mono_framebuffer_rect_fill_core_tb: done, clean");
    end else begin
      $display("mono_framebuffer_rect_fill_core_tb: done, errors");
    end
    $finish;
  end

  // Stop a hung run: about 1500 beats at worst-case fill length plus gaps, taken five times.
  initial begin : watchdog
    #(64_000_000);
    $display("mono_framebuffer_rect_fill_core_tb: done, errors");
    $finish;
  end

endmodule
